>>> rtl/core/tvdi_pkg.sv
package tvdi_pkg;

  localparam int COMP_W   = 32;
  localparam int NUM_COMP = 8;
  localparam int TOL_W    = 31;
  localparam int VIDX_W   = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd655;

  typedef struct packed {
    logic                     start_mesh;
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] tex_u;
    logic signed [COMP_W-1:0] tex_v;
    logic signed [COMP_W-1:0] norm_x;
    logic signed [COMP_W-1:0] norm_y;
    logic signed [COMP_W-1:0] norm_z;
  } vertex_t;

  typedef struct packed {
    logic [VIDX_W-1:0] vertex_index;
    logic              is_new;
    logic              table_full;
  } result_t;

  // Compare token that walks down the cell row (entry index travels beside it).
  typedef struct packed {
    logic valid;
    logic hit;
  } token_t;

endpackage

>>> rtl/core/tolerant_vertex_dedup_indexer.sv
// Tolerant vertex de-duplicating indexer.
//
// Usage: drive one vertex on "vertex" and pulse "start" while "busy" is low;
// the word is taken at that edge. Exactly one result word appears later on
// "result" with "done" high for a single cycle; the receiver cannot stall,
// so capture it then. The user writes the tolerance register through
// cfg_valid / cfg_ready / cfg_data while idle, not enforced; cfg_ready is always high.
//
// The table is a row of eight cells, one per vertex component, each owning
// that component's column memory. Entry indexes are injected one per cycle
// and walk down the row, each cell ANDing its compare into the hit flag.
// On an empty table the result follows the first scan state; otherwise it
// comes when the first matching entry leaves the last cell, or when the last
// stored entry leaves it with no match. Entries enter one per cycle and pass
// through eight cells. One vertex is handled at a time; busy drops in the
// cycle the result is shown, so the next word can be taken at the edge that
// takes the result.
//
// Reset clears the entry count and the tolerance (back to about 0.01);
// the table memories are not cleared, only entries below the count are read.
module tolerant_vertex_dedup_indexer #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  tvdi_pkg::vertex_t            vertex,
  output logic                         done,
  output tvdi_pkg::result_t            result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tvdi_pkg::TOL_W-1:0]   cfg_data
);
  import tvdi_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] issue;
  logic [TOL_W-1:0] tol;
  logic             accept;
  logic             kill;
  logic             wr_en;
  logic             last;
  logic             hit_found;
  logic             scan_over;
  logic             full;

  logic [COMP_W-1:0] comp [NUM_COMP];
  token_t            tok  [NUM_COMP+1];
  logic [IDX_W-1:0]  idx  [NUM_COMP+1];

  assign accept    = start & ~busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Tolerance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  // Broadcast components into the cells in row order.
  assign comp[0] = vertex.pos_x;
  assign comp[1] = vertex.pos_y;
  assign comp[2] = vertex.pos_z;
  assign comp[3] = vertex.tex_u;
  assign comp[4] = vertex.tex_v;
  assign comp[5] = vertex.norm_x;
  assign comp[6] = vertex.norm_y;
  assign comp[7] = vertex.norm_z;

  // Inject the next stored entry each cycle while scanning.
  always_comb begin
    tok[0].valid = (state == S_SCAN) && (issue < count);
    tok[0].hit   = 1'b1;
    idx[0]       = issue[IDX_W-1:0];
  end

  for (genvar g = 0; g < NUM_COMP; g++) begin : g_cell
    tvdi_cell #(
      .DEPTH (TABLE_DEPTH),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .load       (accept),
      .load_value (comp[g]),
      .wr_en      (wr_en),
      .wr_addr    (count[IDX_W-1:0]),
      .kill       (kill),
      .tol        (tol),
      .tok_in     (tok[g]),
      .idx_in     (idx[g]),
      .tok_out    (tok[g+1]),
      .idx_out    (idx[g+1])
    );
  end

  // Tokens leave the row in index order; the first hit wins.
  always_comb begin
    last      = (CNT_W'(idx[NUM_COMP]) == count - CNT_W'(1));
    hit_found = (state == S_SCAN) && tok[NUM_COMP].valid && tok[NUM_COMP].hit;
    scan_over = (state == S_SCAN) && !hit_found &&
                ((count == '0) || (tok[NUM_COMP].valid && last));
    full      = (count == CNT_W'(TABLE_DEPTH));
    kill      = hit_found || scan_over;
    wr_en     = scan_over && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      issue <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            issue <= '0;
            if (vertex.start_mesh) begin
              count <= '0;
            end
          end
        end
        S_SCAN: begin
          if (tok[0].valid) begin
            issue <= issue + CNT_W'(1);
          end
          if (kill) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
          if (wr_en) begin
            count <= count + CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word; held until the next one is formed.
  always_ff @(posedge clk) begin
    if (hit_found) begin
      result.vertex_index <= VIDX_W'(idx[NUM_COMP]);
      result.is_new       <= 1'b0;
      result.table_full   <= 1'b0;
    end else if (scan_over) begin
      result.vertex_index <= full ? '0 : VIDX_W'(count);
      result.is_new       <= !full;
      result.table_full   <= full;
    end
  end

endmodule

>>> rtl/core/tvdi_cell.sv
module tvdi_cell #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic [tvdi_pkg::COMP_W-1:0]  load_value,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  logic                         kill,
  input  logic [tvdi_pkg::TOL_W-1:0]   tol,
  input  tvdi_pkg::token_t             tok_in,
  input  logic [IDX_W-1:0]             idx_in,
  output tvdi_pkg::token_t             tok_out,
  output logic [IDX_W-1:0]             idx_out
);
  import tvdi_pkg::*;

  logic [COMP_W-1:0] mem [DEPTH];
  logic [COMP_W-1:0] query;
  logic [COMP_W-1:0] rd_data;
  token_t            tok;
  logic [IDX_W-1:0]  idx;
  logic [COMP_W:0]   diff;
  logic [COMP_W:0]   mag;
  logic              close;

  // One component column of the table; stores the held query component.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= query;
    end
    rd_data <= mem[idx_in];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      query <= load_value;
    end
    idx <= idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok.valid <= tok_in.valid & ~kill;
      tok.hit   <= tok_in.hit;
    end
  end

  // Exact 33-bit distance, magnitude fits 33 bits unsigned.
  always_comb begin
    diff  = {query[COMP_W-1], query} - {rd_data[COMP_W-1], rd_data};
    mag   = diff[COMP_W] ? (~diff + 1'b1) : diff;
    close = mag < {2'b00, tol};
  end

  always_comb begin
    tok_out.valid = tok.valid;
    tok_out.hit   = tok.hit & close;
  end

  assign idx_out = idx;

endmodule
